// File: rtl/lse_pkg.sv
// shared types and constants for the lsb stego extractor
`timescale 1ns / 1ps

package lse_pkg;

    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [7:0] HEADER_BYTES_RST = 8'd54;
    localparam logic [7:0] MAGIC_FIRST_RST  = 8'd35;
    localparam logic [7:0] MAGIC_SECOND_RST = 8'd42;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_FIRST  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_SECOND = 2'd2;

    localparam logic [1:0] KIND_EXT    = 2'd0;
    localparam logic [1:0] KIND_PAY    = 2'd1;
    localparam logic [1:0] KIND_BADMAG = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    typedef struct packed {
        logic [7:0] header_bytes;
        logic [7:0] magic_first;
        logic [7:0] magic_second;
    } lse_cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       payload_last;
    } lse_res_t;

endpackage

// File: rtl/lse_step.sv
// extraction state and per-item decode logic
`timescale 1ns / 1ps

module lse_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  lse_pkg::lse_cfg_t cfg,
    input  logic              en,
    input  logic [7:0]        image_byte,
    input  logic              image_start,
    output logic              res_valid,
    output lse_pkg::lse_res_t res
);
    import lse_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_MAGIC   = 3'd1,
        PH_EXT_LEN = 3'd2,
        PH_EXT     = 3'd3,
        PH_PAY_LEN = 3'd4,
        PH_PAY     = 3'd5,
        PH_DONE    = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  header_count_reg, header_count_next;
    logic [4:0]  bit_count_reg, bit_count_next;
    logic [31:0] bit_gather_reg, bit_gather_next;
    logic [31:0] length_left_reg, length_left_next;
    logic        magic_index_reg, magic_index_next;

    logic [31:0] gathered;
    logic [31:0] clean_len;
    logic [31:0] len_dec;
    logic [4:0]  need_m1;
    logic [4:0]  bit_count_adv;
    logic        done;
    logic [7:0]  magic_exp;
    logic        hit;

    always_comb begin
        phase_next        = image_start ? PH_HEADER : phase_reg;
        header_count_next = image_start ? 8'd0 : header_count_reg;
        bit_count_next    = image_start ? 5'd0 : bit_count_reg;
        bit_gather_next   = image_start ? 32'd0 : bit_gather_reg;
        length_left_next  = image_start ? 32'd0 : length_left_reg;
        magic_index_next  = image_start ? 1'b0 : magic_index_reg;
        hit = 1'b0;
        res = '0;

        if (phase_next == PH_HEADER) begin
            if (header_count_next < cfg.header_bytes) begin
                header_count_next = header_count_next + 8'd1;
            end else begin
                phase_next      = PH_MAGIC;
                bit_count_next  = 5'd0;
                bit_gather_next = 32'd0;
            end
        end

        need_m1 = (phase_next == PH_EXT_LEN || phase_next == PH_PAY_LEN) ?
                  5'(WORD_BITS - 1) : 5'(BYTE_BITS - 1);
        gathered      = bit_gather_next | (32'(image_byte[0]) << bit_count_next);
        done          = bit_count_next >= need_m1;
        bit_count_adv = done ? 5'd0 : bit_count_next + 5'd1;
        clean_len     = gathered[31] ? 32'd0 : gathered;
        len_dec       = length_left_next - 32'd1;
        magic_exp     = magic_index_next ? cfg.magic_second : cfg.magic_first;

        unique case (phase_next)
            PH_HEADER: begin
            end
            PH_MAGIC: begin
                bit_count_next  = bit_count_adv;
                bit_gather_next = done ? 32'd0 : gathered;
                if (done) begin
                    if (gathered[7:0] != magic_exp) begin
                        phase_next   = PH_DONE;
                        hit          = 1'b1;
                        res.out_kind = KIND_BADMAG;
                    end else if (magic_index_next) begin
                        magic_index_next = 1'b0;
                        phase_next       = PH_EXT_LEN;
                    end else begin
                        magic_index_next = 1'b1;
                    end
                end
            end
            PH_EXT_LEN: begin
                bit_count_next  = bit_count_adv;
                bit_gather_next = done ? 32'd0 : gathered;
                if (done) begin
                    length_left_next = clean_len;
                    phase_next = (clean_len != 32'd0) ? PH_EXT : PH_PAY_LEN;
                end
            end
            PH_EXT: begin
                bit_count_next  = bit_count_adv;
                bit_gather_next = done ? 32'd0 : gathered;
                if (done) begin
                    length_left_next = len_dec;
                    if (len_dec == 32'd0) begin
                        phase_next = PH_PAY_LEN;
                    end
                    hit          = 1'b1;
                    res.out_byte = gathered[7:0];
                    res.out_kind = KIND_EXT;
                end
            end
            PH_PAY_LEN: begin
                bit_count_next  = bit_count_adv;
                bit_gather_next = done ? 32'd0 : gathered;
                if (done) begin
                    length_left_next = clean_len;
                    if (clean_len == 32'd0) begin
                        phase_next   = PH_DONE;
                        hit          = 1'b1;
                        res.out_kind = KIND_EMPTY;
                    end else begin
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                bit_count_next  = bit_count_adv;
                bit_gather_next = done ? 32'd0 : gathered;
                if (done) begin
                    length_left_next = len_dec;
                    if (len_dec == 32'd0) begin
                        phase_next       = PH_DONE;
                        res.payload_last = 1'b1;
                    end
                    hit          = 1'b1;
                    res.out_byte = gathered[7:0];
                    res.out_kind = KIND_PAY;
                end
            end
            default: begin
            end
        endcase

        res_valid = en && hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= 8'd0;
            bit_count_reg    <= 5'd0;
            bit_gather_reg   <= 32'd0;
            length_left_reg  <= 32'd0;
            magic_index_reg  <= 1'b0;
        end else if (en) begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            bit_count_reg    <= bit_count_next;
            bit_gather_reg   <= bit_gather_next;
            length_left_reg  <= length_left_next;
            magic_index_reg  <= magic_index_next;
        end
    end

    a_last_only_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.payload_last |-> res.out_kind == KIND_PAY)
        else $error("last flag on a non-payload result");

    a_status_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.out_kind == KIND_BADMAG || res.out_kind == KIND_EMPTY)
        |-> res.out_byte == 8'd0)
        else $error("status result carries a data byte");

    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        en && !image_start && phase_reg == PH_DONE |-> !res_valid)
        else $error("result after extraction finished");

endmodule

// File: rtl/lse_out_buf.sv
// two-entry result register with skid slot
`timescale 1ns / 1ps

module lse_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lse_pkg::lse_res_t push_res,
    output logic              full,
    output logic              out_valid,
    output lse_pkg::lse_res_t out_res,
    input  logic              out_ready
);
    import lse_pkg::*;

    lse_res_t   head_reg, head_next;
    lse_res_t   tail_reg, tail_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = cnt_reg != 2'd0;
    assign out_res   = head_reg;
    assign full      = cnt_reg == 2'd2;
    assign pop       = out_valid && out_ready;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
        case (cnt_reg)
            2'd0: begin
                if (push) head_next = push_res;
            end
            2'd1: begin
                if (push && pop) head_next = push_res;
                else if (push) tail_next = push_res;
            end
            default: begin
                if (pop) head_next = tail_reg;
                if (push) tail_next = push_res;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && cnt_reg == 2'd2 |-> pop)
        else $error("result pushed into a full buffer");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

endmodule

// File: rtl/lsb_stego_extractor_core.sv
// top level of the lsb stego extractor
`timescale 1ns / 1ps

// Takes one carrier image byte per item and recovers the hidden stream from
// bit 0 of each byte after the configured header: two magic bytes, the
// extension length and characters, the payload length and the payload bytes.
// One item is accepted every cycle while s_tready is high; a result becomes
// valid once its item has passed the input register and then the result
// buffer. s_tready drops only while both result slots hold results the sink
// has not taken and the input register holds an item. Each item is decoded
// by the combinational state update in lse_step, which bounds the rate at
// one item per clock. Setting image_start restarts extraction with that
// byte; configuration writes are taken every cycle.

module lsb_stego_extractor_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // image_byte
    input  logic [0:0]                         s_tuser,   // image_start
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // out_byte
    output logic [1:0]                         m_tuser,   // out_kind
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lse_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                         cfg_data
);
    import lse_pkg::*;

    lse_cfg_t   cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       full;
    logic       advance;
    logic       res_valid;
    lse_res_t   res;
    lse_res_t   out_res;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && !full;
    assign s_tready  = !in_valid_reg || !full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_bytes <= HEADER_BYTES_RST;
            cfg_reg.magic_first  <= MAGIC_FIRST_RST;
            cfg_reg.magic_second <= MAGIC_SECOND_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HEADER_BYTES: cfg_reg.header_bytes <= cfg_data;
                CFG_MAGIC_FIRST:  cfg_reg.magic_first  <= cfg_data;
                CFG_MAGIC_SECOND: cfg_reg.magic_second <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    lse_step u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .en          (advance),
        .image_byte  (in_byte_reg),
        .image_start (in_start_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    lse_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_res  (res),
        .full      (full),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = out_res.out_kind;
    assign m_tlast = out_res.payload_last;

endmodule
